// ----- rtl/core/ffoa_pkg.sv -----
package ffoa_pkg;

  localparam int FIELD_W         = 24;
  localparam int DEF_MAX_REGIONS = 64;
  localparam int DEF_ADDR_BITS   = 24;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic active;
    logic found;
    logic eq;
  } wave_ctl_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } commit_t;

endpackage

// ----- rtl/core/first_fit_offset_allocator_unit.sv -----
// First-fit offset allocator.
// Requests enter on the in_ channel: in_tuser selects allocate (0) or free (1),
// and in_tdata carries the length to allocate and the start offset to free.
// Each request yields one result on the out_ channel with a status, the start
// chosen by an allocation and the length released by a free.
// The region table lives in a row of MAX_REGIONS cells, one region per cell.
// A scan wave enters the first cell and moves one cell per cycle; the
// result it brings out of the last cell is registered and appears on
// out_tvalid at the same edge at which in_tready returns high. One request
// is in flight at a time: the next is accepted only once in_tready is high again.
// An update shifts the cells from the chosen slot on; earlier cells keep theirs.
// A finished result sits in an output register; while the receiver stalls,
// the next request may still be accepted and scanned, and its result waits
// until the register is free. Reset empties the table at once: no clearing
// pass is needed, and in_tready is high in the first cycle after reset.
module first_fit_offset_allocator_unit #(
  parameter int MAX_REGIONS = ffoa_pkg::DEF_MAX_REGIONS,
  parameter int ADDR_BITS   = ffoa_pkg::DEF_ADDR_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [23:0] req_length, [47:24] free_start
  input  logic [ffoa_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] kind
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [1:0] status, [25:2] alloc_start, [49:26] freed_length, [55:50] zero
  output logic [ffoa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ffoa_pkg::*;

  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int AW = ADDR_BITS;
  localparam int PW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 1;
  localparam logic [PW:0] LIMIT = (PW + 1)'(1) << ADDR_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               kind_r;
  logic [FIELD_W-1:0] req_r;
  wave_ctl_t          launch_r;
  commit_t            commit_r, commit_nxt;
  logic [AW-1:0]      new_start_r;
  logic [1:0]         res_status_r;
  logic [FIELD_W-1:0] res_start_r, res_len_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [FIELD_W-1:0] out_start_r, out_len_r;

  wave_ctl_t          wave_chain [0:MAX_REGIONS];
  logic [PW-1:0]      val_chain  [0:MAX_REGIONS];
  logic [AW-1:0]      ext_start  [0:MAX_REGIONS+1];
  logic [FIELD_W-1:0] ext_len    [0:MAX_REGIONS+1];

  logic               accept, out_free;
  wave_ctl_t          tail;
  logic [PW-1:0]      tail_val;
  logic [PW:0]        end_sum;
  logic [1:0]         status_c;
  logic [FIELD_W-1:0] start_c, len_c;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign wave_chain[0]           = launch_r;
  assign val_chain[0]            = '0;
  assign ext_start[0]            = '0;
  assign ext_len[0]              = '0;
  assign ext_start[MAX_REGIONS+1] = '0;
  assign ext_len[MAX_REGIONS+1]   = '0;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    ffoa_cell #(
      .IDX (i),
      .CW  (CW),
      .AW  (AW),
      .PW  (PW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .count       (count_r),
      .kind        (kind_r),
      .req         (req_r),
      .wave_in     (wave_chain[i]),
      .val_in      (val_chain[i]),
      .wave_out    (wave_chain[i+1]),
      .val_out     (val_chain[i+1]),
      .commit      (commit_r),
      .new_start   (new_start_r),
      .new_len     (req_r),
      .left_start  (ext_start[i]),
      .left_len    (ext_len[i]),
      .right_start (ext_start[i+2]),
      .right_len   (ext_len[i+2]),
      .start_o     (ext_start[i+1]),
      .len_o       (ext_len[i+1])
    );
  end

  assign tail     = wave_chain[MAX_REGIONS];
  assign tail_val = val_chain[MAX_REGIONS];

  always_comb begin
    end_sum    = (PW + 1)'(tail_val) + (PW + 1)'(req_r);
    status_c   = ST_OK;
    start_c    = '0;
    len_c      = '0;
    commit_nxt = '0;
    count_nxt  = count_r;
    if (kind_r == KIND_ALLOC) begin
      if (end_sum > LIMIT) begin
        status_c = ST_OVERFLOW;
      end else if (tail.found && tail.eq) begin
        start_c = tail_val[FIELD_W-1:0];
      end else if (count_r == CW'(MAX_REGIONS)) begin
        status_c = ST_FULL;
      end else begin
        start_c        = tail_val[FIELD_W-1:0];
        commit_nxt.ins = 1'b1;
        count_nxt      = count_r + CW'(1);
      end
    end else begin
      if (tail.found) begin
        len_c          = tail_val[FIELD_W-1:0];
        commit_nxt.rem = 1'b1;
        count_nxt      = count_r - CW'(1);
      end else begin
        status_c = ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.active) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      launch_r    <= '0;
      commit_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      launch_r.active <= accept;
      launch_r.found  <= 1'b0;
      launch_r.eq     <= 1'b0;
      if ((state_r == S_SCAN) && tail.active) begin
        commit_r <= commit_nxt;
        count_r  <= count_nxt;
      end else begin
        commit_r <= '0;
      end
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_tuser;
      req_r  <= (in_tuser == KIND_FREE) ? in_tdata[2*FIELD_W-1:FIELD_W]
                                        : in_tdata[FIELD_W-1:0];
    end
    if ((state_r == S_SCAN) && tail.active) begin
      new_start_r  <= tail_val[AW-1:0];
      res_status_r <= status_c;
      res_start_r  <= start_c;
      res_len_r    <= len_c;
    end
    if ((state_r == S_OUT) && out_free) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
      out_len_r    <= res_len_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 2 - 2 * FIELD_W)'(0), out_len_r, out_start_r,
                       out_status_r};

endmodule

// ----- rtl/core/ffoa_cell.sv -----
module ffoa_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int AW  = 24,
  parameter int PW  = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [CW-1:0]              count,
  input  logic                       kind,
  input  logic [ffoa_pkg::FIELD_W-1:0] req,
  input  ffoa_pkg::wave_ctl_t        wave_in,
  input  logic [PW-1:0]              val_in,
  output ffoa_pkg::wave_ctl_t        wave_out,
  output logic [PW-1:0]              val_out,
  input  ffoa_pkg::commit_t          commit,
  input  logic [AW-1:0]              new_start,
  input  logic [ffoa_pkg::FIELD_W-1:0] new_len,
  input  logic [AW-1:0]              left_start,
  input  logic [ffoa_pkg::FIELD_W-1:0] left_len,
  input  logic [AW-1:0]              right_start,
  input  logic [ffoa_pkg::FIELD_W-1:0] right_len,
  output logic [AW-1:0]              start_o,
  output logic [ffoa_pkg::FIELD_W-1:0] len_o
);
  import ffoa_pkg::*;

  logic [AW-1:0]      start_r;
  logic [FIELD_W-1:0] len_r;
  wave_ctl_t          wave_r, wave_nxt;
  logic [PW-1:0]      val_r, val_nxt;
  logic               is_slot_r, past_slot_r;
  logic               valid, hit, eq_here;
  logic [PW-1:0]      s_ext, l_ext, req_ext, gap, end_here;

  always_comb begin
    valid    = CW'(IDX) < count;
    s_ext    = PW'(start_r);
    l_ext    = PW'(len_r);
    req_ext  = PW'(req);
    gap      = s_ext - val_in;
    end_here = s_ext + l_ext;
    if (kind == KIND_ALLOC) begin
      eq_here = valid && (s_ext == val_in);
      hit     = !valid || ((s_ext >= val_in) && (gap >= req_ext));
    end else begin
      eq_here = 1'b0;
      hit     = valid && (s_ext == req_ext);
    end
    wave_nxt.active = wave_in.active;
    wave_nxt.found  = wave_in.found | hit;
    wave_nxt.eq     = wave_in.found ? wave_in.eq : eq_here;
    if (wave_in.found) begin
      val_nxt = val_in;
    end else if (hit) begin
      val_nxt = (kind == KIND_ALLOC) ? val_in : l_ext;
    end else begin
      val_nxt = (kind == KIND_ALLOC) ? end_here : val_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= '0;
      is_slot_r   <= 1'b0;
      past_slot_r <= 1'b0;
    end else begin
      wave_r <= wave_nxt;
      if (wave_in.active) begin
        is_slot_r   <= !wave_in.found && hit;
        past_slot_r <= wave_in.found;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (commit.ins) begin
      if (past_slot_r) begin
        start_r <= left_start;
        len_r   <= left_len;
      end else if (is_slot_r) begin
        start_r <= new_start;
        len_r   <= new_len;
      end
    end else if (commit.rem && (is_slot_r || past_slot_r)) begin
      start_r <= right_start;
      len_r   <= right_len;
    end
  end

  assign wave_out = wave_r;
  assign val_out  = val_r;
  assign start_o  = start_r;
  assign len_o    = len_r;

endmodule

// ----- rtl/core/ffoa_chk.sv -----
module ffoa_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ffoa_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ffoa_pkg::*;

  // Only one request is scanned at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A failed request reports neither a start nor a length.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] != ST_OK)) |->
      ((out_tdata[2+FIELD_W-1:2] == '0) && (out_tdata[2+2*FIELD_W-1:2+FIELD_W] == '0)))
    else $error("failed request carries payload");

endmodule

bind first_fit_offset_allocator_unit ffoa_chk u_ffoa_chk (.*);
